@@ sv/ifns_pkg.sv @@
// shared types and constants for the four-neighbor in-place smoothing block
// no dependencies
package ifns_pkg;

	localparam int MAX_WIDTH  = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int CNT_W      = COL_W + 1;
	localparam int WIDTH_W    = 11;
	localparam int HEIGHT_W   = 16;
	localparam int PIX_W      = 8;
	localparam int SUM_W      = PIX_W + 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 16;

	// configuration register indexes
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = CFG_IDX_W'(1);

	localparam logic [WIDTH_W-1:0]  WIDTH_RESET  = WIDTH_W'(1024);
	localparam logic [HEIGHT_W-1:0] HEIGHT_RESET = HEIGHT_W'(1024);

	// input word kinds
	localparam logic ACT_PIXEL = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef logic [PIX_W-1:0] pixel_t;
	typedef logic [COL_W-1:0] col_t;

	typedef struct packed {
		pixel_t pixel_out;
		logic   frame_last;
	} result_t;

endpackage

@@ sv/ifns_if.sv @@
// stream and configuration channel interfaces for the smoothing block
// depends on ifns_pkg
interface ifns_in_if;
	logic                  valid;
	logic                  ready;
	logic                  action;
	ifns_pkg::pixel_t      pixel_in;

	modport source (output valid, output action, output pixel_in, input ready);
	modport sink (input valid, input action, input pixel_in, output ready);
endinterface

interface ifns_out_if;
	logic                  valid;
	logic                  ready;
	ifns_pkg::pixel_t      pixel_out;
	logic                  frame_last;

	modport source (output valid, output pixel_out, output frame_last, input ready);
	modport sink (input valid, input pixel_out, input frame_last, output ready);
endinterface

interface ifns_cfg_if;
	logic                                 valid;
	logic                                 ready;
	logic [ifns_pkg::CFG_IDX_W-1:0]       index;
	logic [ifns_pkg::CFG_DATA_W-1:0]      data;

	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ sv/ifns_ram.sv @@
// generic single-write, single-read RAM with registered read data
// write-first: a read of the address written in the same cycle returns the new word
module ifns_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (we && (waddr == raddr)) begin
			rdata_q <= wdata;
		end else begin
			rdata_q <= mem[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/ifns_out_buf.sv @@
// two-entry output register with skid slot for result words
// depends on ifns_pkg and ifns_out_if
module ifns_out_buf (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  ifns_pkg::result_t word,
	output logic              room,
	ifns_out_if.source        results
);
	import ifns_pkg::*;

	result_t main_q;
	result_t skid_q;
	logic    main_v_q;
	logic    skid_v_q;
	logic    pop;

	assign pop = main_v_q && results.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			main_v_q <= 1'b0;
			skid_v_q <= 1'b0;
		end else begin
			if (push) begin
				// skid slot is empty whenever a word can be pushed
				if (!main_v_q || pop) begin
					main_v_q <= 1'b1;
				end else begin
					skid_v_q <= 1'b1;
				end
			end else if (pop) begin
				main_v_q <= skid_v_q;
				skid_v_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			if (!main_v_q || pop) begin
				main_q <= word;
			end else begin
				skid_q <= word;
			end
		end else if (pop) begin
			main_q <= skid_q;
		end
	end

	assign room               = !skid_v_q;
	assign results.valid      = main_v_q;
	assign results.pixel_out  = main_q.pixel_out;
	assign results.frame_last = main_q.frame_last;

endmodule

@@ sv/in_place_four_neighbor_smoothing.sv @@
// top level of the four-neighbor in-place smoothing block
// depends on ifns_pkg, ifns_if, ifns_ram and ifns_out_buf
//
// Usage:
//   pixels  : input words, action 0 carries a raster-order pixel, action 1 is a
//             flush tick that drains the last row after the frame.
//   results : smoothed pixels (border pixels unchanged) in raster order, one
//             row behind the input; frame_last marks the final pixel of the frame.
//   cfg     : register writes (0 = image_width, 1 = image_height), always ready;
//             write only while the block is idle.
// Throughput is one word per cycle while pixels.ready is high. Each result
// is pushed into the output buffer when its word is accepted. The line
// buffers are read ahead at the next column, so each word needs only one
// registered read per buffer and one four-way add.
// When the receiver stalls, a skid slot takes one more result; pixels.ready
// drops while that slot is full and rises again once the receiver takes a word.
// Reset clears the counters and the drain state and empties the output; the
// line buffers are not cleared and no pass over them is needed.
module in_place_four_neighbor_smoothing (
	input  logic        clk,
	input  logic        arst_n,
	ifns_in_if.sink     pixels,
	ifns_out_if.source  results,
	ifns_cfg_if.sink    cfg
);
	import ifns_pkg::*;

	logic [WIDTH_W-1:0]  width_q;
	logic [HEIGHT_W-1:0] height_q;
	logic [CNT_W-1:0]    eff_w;
	logic [HEIGHT_W-1:0] eff_h;

	col_t                col_q, col_d;
	logic [HEIGHT_W-1:0] row_q, row_d;
	logic                drain_q, drain_d;
	col_t                dcol_q, dcol_d;
	pixel_t              left_q, left_d;

	logic                in_acc;
	logic                room;
	logic                push;
	result_t             word;

	pixel_t              cur, right, up, val;
	logic [SUM_W-1:0]    sum;
	logic [CNT_W-1:0]    col_inc, dcol_inc;
	logic                row_end, dlast, interior;
	logic                orig_we, upd_we;
	col_t                orig_raddr, right_raddr;

	// configuration
	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= WIDTH_RESET;
			height_q <= HEIGHT_RESET;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				REG_IMAGE_WIDTH:  width_q  <= cfg.data[WIDTH_W-1:0];
				REG_IMAGE_HEIGHT: height_q <= cfg.data[HEIGHT_W-1:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		if (width_q == '0) begin
			eff_w = CNT_W'(1);
		end else if (32'(width_q) > MAX_WIDTH) begin
			eff_w = CNT_W'(MAX_WIDTH);
		end else begin
			eff_w = CNT_W'(width_q);
		end
		eff_h = (height_q == '0) ? HEIGHT_W'(1) : height_q;
	end

	assign pixels.ready = room;
	assign in_acc       = pixels.valid && room;

	// datapath and next state
	always_comb begin
		col_d    = col_q;
		row_d    = row_q;
		drain_d  = drain_q;
		dcol_d   = dcol_q;
		left_d   = left_q;
		orig_we  = 1'b0;
		upd_we   = 1'b0;
		push     = 1'b0;
		word     = '0;

		col_inc  = {1'b0, col_q} + CNT_W'(1);
		dcol_inc = {1'b0, dcol_q} + CNT_W'(1);
		row_end  = col_inc >= eff_w;
		dlast    = dcol_inc >= eff_w;
		interior = (row_q >= HEIGHT_W'(2)) && (row_q < eff_h)
			&& (col_q != '0) && !row_end;
		sum      = SUM_W'(up) + SUM_W'(pixels.pixel_in) + SUM_W'(left_q) + SUM_W'(right);
		val      = interior ? sum[SUM_W-1:2] : cur;

		if (in_acc) begin
			unique case (pixels.action)
				ACT_FLUSH: begin
					if (drain_q) begin
						push            = 1'b1;
						word.pixel_out  = cur;
						word.frame_last = dlast;
						if (dlast) begin
							drain_d = 1'b0;
							dcol_d  = '0;
							row_d   = '0;
							col_d   = '0;
						end else begin
							dcol_d = dcol_inc[COL_W-1:0];
						end
					end
				end
				ACT_PIXEL: begin
					if (!drain_q) begin
						orig_we = 1'b1;
						if (row_q != '0) begin
							push           = 1'b1;
							upd_we         = 1'b1;
							left_d         = val;
							word.pixel_out = val;
						end
						if (row_end) begin
							col_d = '0;
							if (({1'b0, row_q} + (HEIGHT_W+1)'(1)) >= {1'b0, eff_h}) begin
								drain_d = 1'b1;
								dcol_d  = '0;
							end else begin
								row_d = row_q + HEIGHT_W'(1);
							end
						end else begin
							col_d = col_inc[COL_W-1:0];
						end
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q   <= '0;
			row_q   <= '0;
			drain_q <= 1'b0;
			dcol_q  <= '0;
			left_q  <= '0;
		end else begin
			col_q   <= col_d;
			row_q   <= row_d;
			drain_q <= drain_d;
			dcol_q  <= dcol_d;
			left_q  <= left_d;
		end
	end

	// line buffers are addressed with the next state so the data is ready
	// when the next word arrives
	assign orig_raddr  = drain_d ? dcol_d : col_d;
	assign right_raddr = (32'(col_d) == MAX_WIDTH - 1) ? '0 : col_d + COL_W'(1);

	ifns_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_orig_cur (
		.clk   (clk),
		.we    (orig_we),
		.waddr (col_q),
		.wdata (pixels.pixel_in),
		.raddr (orig_raddr),
		.rdata (cur)
	);

	// second copy of the original row for the right neighbor
	ifns_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_orig_right (
		.clk   (clk),
		.we    (orig_we),
		.waddr (col_q),
		.wdata (pixels.pixel_in),
		.raddr (right_raddr),
		.rdata (right)
	);

	ifns_ram #(
		.WIDTH(PIX_W),
		.DEPTH(MAX_WIDTH)
	) u_updated (
		.clk   (clk),
		.we    (upd_we),
		.waddr (col_q),
		.wdata (val),
		.raddr (col_d),
		.rdata (up)
	);

	ifns_out_buf u_out_buf (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.word    (word),
		.room    (room),
		.results (results)
	);

endmodule
